// ----- rtl/mrp_pkg.sv -----
`timescale 1ns / 1ps

package mrp_pkg;

    localparam int LENGTH_BITS_DEF = 9;

    localparam logic [7:0]  EXC_FLAG  = 8'h80;
    localparam logic [7:0]  FC_READ   = 8'h03;
    localparam logic [7:0]  MIN_FRAME = 8'd5;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'hA001;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_TOO_SHORT  = 3'd1,
        ST_CRC_ERROR  = 3'd2,
        ST_EXCEPTION  = 3'd3,
        ST_BAD_FUNC   = 3'd4,
        ST_INCOMPLETE = 3'd5
    } status_t;

    typedef enum logic {
        KIND_WORD   = 1'b0,
        KIND_STATUS = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] reg_value;
        logic [6:0]  reg_index;
        status_t     status;
        logic [7:0]  slave_id;
        logic [7:0]  exception_code;
        logic [6:0]  reg_count;
    } result_t;

    // CRC-16/MODBUS, reflected, one byte
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

// ----- rtl/mrp_frame.sv -----
`timescale 1ns / 1ps

module mrp_frame
    import mrp_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] rx_byte,
    input  logic       end_of_frame,
    output logic       res_valid,
    output result_t    res
);

    localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};
    localparam logic [LENGTH_BITS-1:0] POS_DATA = LENGTH_BITS'(3);

    logic [15:0]            crc_reg, crc_next;
    logic [LENGTH_BITS-1:0] len_reg, len_next;
    logic [7:0]             slave_reg, slave_next;
    logic [7:0]             func_reg, func_next;
    logic [7:0]             data_reg, data_next;
    logic [7:0]             high_reg, high_next;
    logic [6:0]             widx_reg, widx_next;

    logic [LENGTH_BITS-1:0] off;
    logic [LENGTH_BITS:0]   len_ext;
    logic [LENGTH_BITS:0]   need_len;
    logic [LENGTH_BITS:0]   data_ext;
    status_t                st;

    always_comb
    begin
        crc_next   = crc16_byte(crc_reg, rx_byte);
        len_next   = (len_reg == LEN_MAX) ? len_reg : len_reg + 1'b1;
        slave_next = (len_reg == '0) ? rx_byte : slave_reg;
        func_next  = (len_reg == LENGTH_BITS'(1)) ? rx_byte : func_reg;
        data_next  = (len_reg == LENGTH_BITS'(2)) ? rx_byte : data_reg;
        high_next  = high_reg;
        widx_next  = widx_reg;

        off      = len_reg - POS_DATA;
        len_ext  = {1'b0, len_next};
        data_ext = {{(LENGTH_BITS - 7){1'b0}}, data_reg};
        need_len = {{(LENGTH_BITS - 7){1'b0}}, MIN_FRAME}
                 + {{(LENGTH_BITS - 7){1'b0}}, data_next};

        // status priority: first failing check wins
        if (len_ext < {{(LENGTH_BITS - 7){1'b0}}, MIN_FRAME})
            st = ST_TOO_SHORT;
        else if (crc_next != 16'h0000)
            st = ST_CRC_ERROR;
        else if ((func_next & EXC_FLAG) != 8'h00)
            st = ST_EXCEPTION;
        else if (func_next != FC_READ)
            st = ST_BAD_FUNC;
        else if (len_ext < need_len)
            st = ST_INCOMPLETE;
        else
            st = ST_OK;

        res_valid = 1'b0;
        res       = '0;

        if (end_of_frame)
        begin
            res_valid          = 1'b1;
            res.kind           = KIND_STATUS;
            res.status         = st;
            res.slave_id       = slave_next;
            res.exception_code = (st == ST_EXCEPTION) ? data_next : 8'h00;
            res.reg_count      = (st == ST_OK) ? data_next[7:1] : 7'd0;
            // frame done: back to the idle frame state
            crc_next   = CRC_INIT;
            len_next   = '0;
            slave_next = 8'h00;
            func_next  = 8'h00;
            data_next  = 8'h00;
            widx_next  = 7'd0;
        end
        else if (len_reg >= POS_DATA && func_reg == FC_READ)
        begin
            if (!off[0])
            begin
                if ({1'b0, off} + 1'b1 < data_ext)
                    high_next = rx_byte;
            end
            else if ({1'b0, off} < data_ext)
            begin
                res_valid     = 1'b1;
                res.kind      = KIND_WORD;
                res.reg_value = {high_reg, rx_byte};
                res.reg_index = widx_reg;
                res.slave_id  = slave_reg;
                widx_next     = widx_reg + 1'b1;
            end
        end

        if (end_of_frame)
            high_next = 8'h00;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg   <= CRC_INIT;
            len_reg   <= '0;
            slave_reg <= 8'h00;
            func_reg  <= 8'h00;
            data_reg  <= 8'h00;
            high_reg  <= 8'h00;
            widx_reg  <= 7'd0;
        end
        else if (step)
        begin
            crc_reg   <= crc_next;
            len_reg   <= len_next;
            slave_reg <= slave_next;
            func_reg  <= func_next;
            data_reg  <= data_next;
            high_reg  <= high_next;
            widx_reg  <= widx_next;
        end
    end

endmodule

// ----- rtl/mrp_out.sv -----
`timescale 1ns / 1ps

module mrp_out
    import mrp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  logic    res_valid,
    input  result_t res,
    input  logic    out_stall,
    output logic    out_free,
    output logic    out_valid,
    output result_t out_res
);

    logic    valid_reg, valid_next;
    result_t res_reg;

    assign out_free   = !valid_reg || !out_stall;
    assign valid_next = out_free ? (load && res_valid) : valid_reg;
    assign out_valid  = valid_reg;
    assign out_res    = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load && res_valid)
            res_reg <= res;
    end

endmodule

// ----- rtl/modbus_read_response_parser_top.sv -----
`timescale 1ns / 1ps

// Modbus RTU read-holding-registers response parser.
// Input channel: one frame byte per word on rx_byte, end_of_frame set on the
// last byte; accepted when in_valid is high and in_stall is low.
// Output channel: one result word per accepted byte at most. kind 0 is a
// register word (reg_value, reg_index, slave_id), emitted when the second
// byte of a data pair arrives; kind 1 is the frame status, emitted on the
// last byte, carrying status, slave_id, exception_code and reg_count.
// Words of a frame whose status is not ok must be dropped downstream.
// Path from input acceptance to out_valid: input register, then CRC update
// and checks, then output register.
// Throughput: one byte per cycle unless stalled; the byte-wide CRC update
// and the checks fit in the single logic stage between the two registers.
// Stall: when out_stall holds a pending result, the input register stops
// and in_stall rises while it is occupied; nothing is lost or repeated.
// Reset: clears the frame state (CRC to 0xFFFF, counters to zero) and
// empties both registers; no clearing pass is needed.
module modbus_read_response_parser_top
    import mrp_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    input  logic        end_of_frame,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        kind,
    output logic [15:0] reg_value,
    output logic [6:0]  reg_index,
    output logic [2:0]  status,
    output logic [7:0]  slave_id,
    output logic [7:0]  exception_code,
    output logic [6:0]  reg_count
);

    // input register
    logic       in_valid_reg;
    logic [7:0] byte_reg;
    logic       eof_reg;

    logic    out_free;
    logic    step;
    logic    res_valid;
    result_t res;
    result_t out_res;

    // the held byte moves on whenever the output register can take a result
    assign step     = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!in_stall)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            byte_reg <= rx_byte;
            eof_reg  <= end_of_frame;
        end
    end

    mrp_frame #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_frame (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .rx_byte      (byte_reg),
        .end_of_frame (eof_reg),
        .res_valid    (res_valid),
        .res          (res)
    );

    mrp_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step),
        .res_valid (res_valid),
        .res       (res),
        .out_stall (out_stall),
        .out_free  (out_free),
        .out_valid (out_valid),
        .out_res   (out_res)
    );

    assign kind           = out_res.kind;
    assign reg_value      = out_res.reg_value;
    assign reg_index      = out_res.reg_index;
    assign status         = out_res.status;
    assign slave_id       = out_res.slave_id;
    assign exception_code = out_res.exception_code;
    assign reg_count      = out_res.reg_count;

endmodule

// ----- sim/modbus_read_response_parser_top_test.sv -----
`timescale 1ns / 1ps

import mrp_pkg::*;

// One byte of CRC-16/MODBUS, reflected form, bit at a time.
function automatic logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    r = acc;
    for (int n = 0; n < 8; n++)
    begin
        if ((r[0] ^ b[n]) == 1'b1)
            r = (r >> 1) ^ CRC_POLY;
        else
            r = r >> 1;
    end
    return r;
endfunction

// Frame tracker: mirrors the parser's frame state and queues the words it should emit.
class frame_scoreboard;
    logic [15:0]  crc;
    int unsigned  frame_len;
    int unsigned  len_max;
    logic [7:0]   sid;
    logic [7:0]   fc;
    logic [7:0]   byte_count;
    logic [7:0]   pending_hi;
    logic [6:0]   word_idx;
    result_t      expected_q[$];
    int           errors;

    function new(int len_bits);
        len_max = (1 << len_bits) - 1;
        errors = 0;
        clear_frame();
    endfunction

    function void clear_frame();
        crc = CRC_INIT;
        frame_len = 0;
        sid = '0;
        fc = '0;
        byte_count = '0;
        pending_hi = '0;
        word_idx = '0;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    function void note_byte(logic [7:0] b, logic last);
        int unsigned pos;
        int unsigned off;
        status_t     st;
        result_t     r;
        pos = frame_len;
        crc = crc_step(crc, b);
        if (frame_len < len_max)
            frame_len++;
        if (pos == 0)
            sid = b;
        else if (pos == 1)
            fc = b;
        else if (pos == 2)
            byte_count = b;
        r = '0;
        if (last)
        begin
            if (frame_len < int'(MIN_FRAME))
                st = ST_TOO_SHORT;
            else if (crc != 16'h0000)
                st = ST_CRC_ERROR;
            else if ((fc & EXC_FLAG) != 8'h00)
                st = ST_EXCEPTION;
            else if (fc != FC_READ)
                st = ST_BAD_FUNC;
            else if (frame_len < int'(MIN_FRAME) + int'(byte_count))
                st = ST_INCOMPLETE;
            else
                st = ST_OK;
            r.kind = KIND_STATUS;
            r.status = st;
            r.slave_id = sid;
            r.exception_code = (st == ST_EXCEPTION) ? byte_count : 8'h00;
            r.reg_count = (st == ST_OK) ? byte_count[7:1] : 7'd0;
            expected_q.push_back(r);
            clear_frame();
            return;
        end
        // data pairs start at byte 3; the unpaired tail byte never makes a word
        if (pos >= 3 && fc == FC_READ)
        begin
            off = pos - 3;
            if (off % 2 == 0)
            begin
                if (off + 1 < byte_count)
                    pending_hi = b;
            end
            else if (off < byte_count)
            begin
                r.kind = KIND_WORD;
                r.reg_value = {pending_hi, b};
                r.reg_index = word_idx;
                r.slave_id = sid;
                expected_q.push_back(r);
                word_idx = word_idx + 7'd1;
            end
        end
    endfunction

    function bit field_ok(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    function void check_result(result_t got);
        result_t exp_r;
        bit      ok;
        if (expected_q.size() == 0)
        begin
            $display("%0t: unexpected result, expected none, got %0h", $time, got);
            errors++;
            return;
        end
        exp_r = expected_q.pop_front();
        ok = 1'b1;
        ok &= field_ok("kind", exp_r.kind, got.kind);
        ok &= field_ok("reg_value", exp_r.reg_value, got.reg_value);
        ok &= field_ok("reg_index", exp_r.reg_index, got.reg_index);
        ok &= field_ok("status", exp_r.status, got.status);
        ok &= field_ok("slave_id", exp_r.slave_id, got.slave_id);
        ok &= field_ok("exception_code", exp_r.exception_code, got.exception_code);
        ok &= field_ok("reg_count", exp_r.reg_count, got.reg_count);
        if (!ok)
            errors++;
    endfunction
endclass

module modbus_read_response_parser_top_test;

    localparam int LEN_BITS    = LENGTH_BITS_DEF;
    localparam int HOLD_CYCLES = 80;      // long receiver hold-off
    localparam int DRAIN_WAIT  = 8;       // margin for the output path to drain
    localparam int CYCLE_LIMIT = 300000;
    localparam int PHASE_ITEMS = 220;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_byte = 8'h00;
    logic        end_of_frame = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        kind;
    logic [15:0] reg_value;
    logic [6:0]  reg_index;
    logic [2:0]  status;
    logic [7:0]  slave_id;
    logic [7:0]  exception_code;
    logic [6:0]  reg_count;

    frame_scoreboard sb = new(LEN_BITS);

    int          in_idle_pct = 0;
    int          out_idle_pct = 0;
    bit          hold_req = 1'b0;
    int unsigned items_sent = 0;
    int unsigned cycle_count = 0;
    logic [7:0]  frame_bytes[$];

    modbus_read_response_parser_top #(.LENGTH_BITS(LEN_BITS)) uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .rx_byte        (rx_byte),
        .end_of_frame   (end_of_frame),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .kind           (kind),
        .reg_value      (reg_value),
        .reg_index      (reg_index),
        .status         (status),
        .slave_id       (slave_id),
        .exception_code (exception_code),
        .reg_count      (reg_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 0;
    end

    // Watchdog: a stuck handshake or a missing word ends the run here.
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Both channels are sampled on the edge that accepts a word, before any
    // register update of that edge lands.
    always @(posedge clk)
    begin : monitor
        result_t got;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_byte(rx_byte, end_of_frame);
            if (out_valid && !out_stall)
            begin
                got.kind = kind_t'(kind);
                got.reg_value = reg_value;
                got.reg_index = reg_index;
                got.status = status_t'(status);
                got.slave_id = slave_id;
                got.exception_code = exception_code;
                got.reg_count = reg_count;
                sb.check_result(got);
            end
        end
    end

    // Receiver: random stall at the phase rate; on request a long hold-off so
    // the output and input registers fill and in_stall rises.
    initial
    begin : receiver
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            out_stall <= (int'($urandom_range(99)) < out_idle_pct);
        end
    end

    // Offers one byte, with random idle cycles ahead of it, and returns on the
    // edge that accepts it; valid is left high for the next byte.
    task automatic send_byte(input logic [7:0] b, input logic last);
        while (int'($urandom_range(99)) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        end_of_frame <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_frame();
        foreach (frame_bytes[i])
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    endtask

    // Sender pause: drop valid and wait for every queued word to come back.
    task automatic wait_drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    function automatic void push_crc();
        logic [15:0] c;
        c = CRC_INIT;
        foreach (frame_bytes[i])
            c = crc_step(c, frame_bytes[i]);
        frame_bytes.push_back(c[7:0]);
        frame_bytes.push_back(c[15:8]);
    endfunction

    // Read response: byte count bc, data_len data bytes actually present,
    // extra bytes between data and CRC, valid CRC.
    function automatic void build_read(int bc, int data_len, int extra);
        frame_bytes.delete();
        frame_bytes.push_back(8'($urandom_range(255)));
        frame_bytes.push_back(FC_READ);
        frame_bytes.push_back(8'(bc));
        repeat (data_len + extra)
            frame_bytes.push_back(8'($urandom_range(255)));
        push_crc();
    endfunction

    function automatic void build_random_frame();
        int          sel;
        int          bc;
        int          n;
        logic [7:0]  f;
        sel = $urandom_range(99);
        if ($urandom_range(9) == 0)
            bc = $urandom_range(17, 255);
        else
            bc = $urandom_range(0, 16);
        if (sel < 60)
            build_read(bc, bc, 0);
        else if (sel < 67)
        begin
            // exception reply: code in byte 2
            frame_bytes.delete();
            frame_bytes.push_back(8'($urandom_range(255)));
            frame_bytes.push_back(EXC_FLAG | 8'($urandom_range(127)));
            frame_bytes.push_back(8'($urandom_range(255)));
            push_crc();
        end
        else if (sel < 73)
        begin
            // other function code with data bytes that must not become words
            do
                f = 8'($urandom_range(127));
            while (f == FC_READ);
            n = $urandom_range(0, 8);
            frame_bytes.delete();
            frame_bytes.push_back(8'($urandom_range(255)));
            frame_bytes.push_back(f);
            frame_bytes.push_back(8'(n));
            repeat (n)
                frame_bytes.push_back(8'($urandom_range(255)));
            push_crc();
        end
        else if (sel < 79)
        begin
            // truncated data, CRC still good
            bc = $urandom_range(1, 20);
            build_read(bc, $urandom_range(0, bc - 1), 0);
        end
        else if (sel < 85)
        begin
            // single flipped bit anywhere
            build_read(bc, bc, 0);
            n = $urandom_range(0, frame_bytes.size() - 1);
            frame_bytes[n] = frame_bytes[n] ^ (8'h01 << $urandom_range(7));
        end
        else if (sel < 89)
            build_read(bc, bc, $urandom_range(1, 6));
        else if (sel < 94)
        begin
            frame_bytes.delete();
            repeat ($urandom_range(1, 4))
                frame_bytes.push_back(8'($urandom_range(255)));
        end
        else
        begin
            frame_bytes.delete();
            repeat ($urandom_range(1, 30))
                frame_bytes.push_back(8'($urandom_range(255)));
        end
    endfunction

    task automatic run_phase(int tx_pct, int rx_pct, int budget);
        int unsigned start;
        start = items_sent;
        in_idle_pct = tx_pct;
        out_idle_pct = rx_pct;
        while (items_sent - start < budget)
        begin
            build_random_frame();
            send_frame();
            if ($urandom_range(19) == 0)
                wait_drain();
        end
        wait_drain();
    endtask

    initial
    begin : stimulus
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed frames, no idling
        frame_bytes = '{8'hFF};
        send_frame();
        frame_bytes = '{8'h00, FC_READ, 8'h01, 8'hAB};     // odd byte count
        push_crc();
        send_frame();
        frame_bytes = '{8'hFF, FC_READ, 8'h04, 8'hFF, 8'hFF, 8'h00, 8'h00};
        push_crc();
        send_frame();
        frame_bytes = '{8'h11, 8'h83, 8'h02};              // exception reply
        push_crc();
        send_frame();
        frame_bytes = '{8'h22, 8'h04, 8'h00};              // wrong function
        push_crc();
        send_frame();
        wait_drain();

        // sender idles a little, receiver a lot; one frame long enough to
        // saturate the length counter
        in_idle_pct = 21;
        out_idle_pct = 62;
        build_read(255, 255, 260);
        send_frame();
        run_phase(21, 62, PHASE_ITEMS);

        run_phase(62, 21, PHASE_ITEMS);

        // no idling; a long receiver hold-off backs the block up first
        in_idle_pct = 0;
        out_idle_pct = 0;
        hold_req = 1'b1;
        build_read(40, 40, 0);
        send_frame();
        wait_drain();
        repeat ($urandom_range(1, 5)) @(posedge clk);
        run_phase(0, 0, PHASE_ITEMS);

        repeat (DRAIN_WAIT) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/mrp_pkg.sv
rtl/mrp_frame.sv
rtl/mrp_out.sv
rtl/modbus_read_response_parser_top.sv
sim/modbus_read_response_parser_top_test.sv
